[rtl/core/hpm_pkg.sv]
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared types and constants for the homography point mapper.
// ----------------------------------------------------------------------------
package hpm_pkg;

	// |numerator| and |w| both stay below 2^49
	localparam int MAG_W = 49;
	localparam int QUO_W = 32;
	localparam int SUM_W = 50;
	localparam int PRD_W = 49;

	typedef enum logic [2:0] {
		REG_ENABLE   = 3'd0,
		REG_COEF_XX  = 3'd1,
		REG_COEF_XY  = 3'd2,
		REG_COEF_XO  = 3'd3,
		REG_COEF_YX  = 3'd4,
		REG_COEF_YY  = 3'd5,
		REG_COEF_YO  = 3'd6,
		REG_PERSP    = 3'd7
	} cfg_reg_t;

	// word handed from one divider cell to the next
	typedef struct packed {
		logic             ok;
		logic             neg_x;
		logic             neg_y;
		logic             ovf_x;
		logic             ovf_y;
		logic [MAG_W-1:0] den;
		logic [MAG_W-1:0] rem_x;
		logic [MAG_W-1:0] rem_y;
		logic [QUO_W-1:0] quo_x;
		logic [QUO_W-1:0] quo_y;
	} div_word_t;

endpackage

[rtl/core/hpm_front.sv]
// ----------------------------------------------------------------------------
// hpm_front
// Products, sums, magnitudes and range precheck ahead of the divider chain.
// ----------------------------------------------------------------------------
module hpm_front import hpm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_vld,
	input  logic [15:0]         image_x,
	input  logic [15:0]         image_y,
	input  logic                en,
	input  logic [31:0]         coef_xx,
	input  logic [31:0]         coef_xy,
	input  logic [31:0]         coef_x_offset,
	input  logic [31:0]         coef_yx,
	input  logic [31:0]         coef_yy,
	input  logic [31:0]         coef_y_offset,
	input  logic [63:0]         perspective_row,
	output logic                out_vld,
	output div_word_t           out_word
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, ok_s3;
	logic signed [PRD_W-1:0] p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1, p_g_s1, p_h_s1;
	logic signed [SUM_W-1:0] nx_s2, ny_s2, w_s2;
	logic signed [SUM_W-1:0] nx_c, ny_c, w_c;
	logic signed [16:0] xs, ys;
	logic [MAG_W-1:0] mx_s3, my_s3, d_s3;
	logic neg_x_s3, neg_y_s3;
	div_word_t word_s4;

	assign xs = $signed({1'b0, image_x});
	assign ys = $signed({1'b0, image_y});

	// offsets carry 16 fractional bits; numerators carry 20
	assign nx_c = SUM_W'(p_xx_s1) + SUM_W'(p_xy_s1)
		+ (SUM_W'($signed(coef_x_offset)) <<< 4);
	assign ny_c = SUM_W'(p_yx_s1) + SUM_W'(p_yy_s1)
		+ (SUM_W'($signed(coef_y_offset)) <<< 4);
	assign w_c  = SUM_W'(p_g_s1) + SUM_W'(p_h_s1) + (SUM_W'(1) <<< 44);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			en_s1   <= en;
			p_xx_s1 <= $signed(coef_xx) * xs;
			p_xy_s1 <= $signed(coef_xy) * ys;
			p_yx_s1 <= $signed(coef_yx) * xs;
			p_yy_s1 <= $signed(coef_yy) * ys;
			p_g_s1  <= $signed(perspective_row[31:0]) * xs;
			p_h_s1  <= $signed(perspective_row[63:32]) * ys;

			en_s2 <= en_s1;
			nx_s2 <= nx_c;
			ny_s2 <= ny_c;
			w_s2  <= w_c;

			ok_s3    <= en_s2 && (w_s2 != '0);
			neg_x_s3 <= nx_s2[SUM_W-1] ^ w_s2[SUM_W-1];
			neg_y_s3 <= ny_s2[SUM_W-1] ^ w_s2[SUM_W-1];
			mx_s3    <= nx_s2[SUM_W-1] ? MAG_W'(-nx_s2) : MAG_W'(nx_s2);
			my_s3    <= ny_s2[SUM_W-1] ? MAG_W'(-ny_s2) : MAG_W'(ny_s2);
			d_s3     <= w_s2[SUM_W-1] ? MAG_W'(-w_s2) : MAG_W'(w_s2);

			// quotient needs more than 32 bits when m*2^8 >= d
			word_s4.ok    <= ok_s3;
			word_s4.neg_x <= neg_x_s3;
			word_s4.neg_y <= neg_y_s3;
			word_s4.ovf_x <= {mx_s3, 8'b0} >= {8'b0, d_s3};
			word_s4.ovf_y <= {my_s3, 8'b0} >= {8'b0, d_s3};
			word_s4.den   <= d_s3;
			word_s4.rem_x <= {mx_s3[MAG_W-9:0], 8'b0};
			word_s4.rem_y <= {my_s3[MAG_W-9:0], 8'b0};
			word_s4.quo_x <= '0;
			word_s4.quo_y <= '0;
		end
	end

	assign out_vld  = v_s4;
	assign out_word = word_s4;

endmodule

[rtl/core/hpm_div_cell.sv]
// ----------------------------------------------------------------------------
// hpm_div_cell
// One restoring-division step for both coordinates, registered.
// ----------------------------------------------------------------------------
module hpm_div_cell import hpm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      in_vld,
	input  div_word_t in_word,
	output logic      out_vld,
	output div_word_t out_word
);

	logic [MAG_W:0] sh_x, sh_y, dif_x, dif_y;
	logic ge_x, ge_y;
	div_word_t nxt;

	assign sh_x  = {in_word.rem_x, 1'b0};
	assign sh_y  = {in_word.rem_y, 1'b0};
	assign dif_x = sh_x - {1'b0, in_word.den};
	assign dif_y = sh_y - {1'b0, in_word.den};
	assign ge_x  = sh_x >= {1'b0, in_word.den};
	assign ge_y  = sh_y >= {1'b0, in_word.den};

	always_comb begin
		nxt       = in_word;
		nxt.rem_x = ge_x ? dif_x[MAG_W-1:0] : sh_x[MAG_W-1:0];
		nxt.rem_y = ge_y ? dif_y[MAG_W-1:0] : sh_y[MAG_W-1:0];
		nxt.quo_x = {in_word.quo_x[QUO_W-2:0], ge_x};
		nxt.quo_y = {in_word.quo_y[QUO_W-2:0], ge_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (adv) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word <= nxt;
		end
	end

endmodule

[rtl/core/hpm_back.sv]
// ----------------------------------------------------------------------------
// hpm_back
// Rounding, range check, sign and output register.
// ----------------------------------------------------------------------------
module hpm_back import hpm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  div_word_t          in_word,
	output logic               out_vld,
	output logic signed [31:0] map_x,
	output logic signed [31:0] map_y,
	output logic               coords_valid
);

	logic v_s1;
	logic ok_s1, neg_x_s1, neg_y_s1;
	logic [QUO_W:0] qx_s1, qy_s1;
	logic up_x, up_y, fit_x, fit_y, good;
	logic [QUO_W:0] lim_x, lim_y;
	logic [QUO_W:0] sx, sy;

	// round half away from zero on the magnitude
	assign up_x = {in_word.rem_x, 1'b0} >= {1'b0, in_word.den};
	assign up_y = {in_word.rem_y, 1'b0} >= {1'b0, in_word.den};

	assign lim_x = neg_x_s1 ? (QUO_W+1)'(33'h0_8000_0000) : (QUO_W+1)'(33'h0_7FFF_FFFF);
	assign lim_y = neg_y_s1 ? (QUO_W+1)'(33'h0_8000_0000) : (QUO_W+1)'(33'h0_7FFF_FFFF);
	assign fit_x = qx_s1 <= lim_x;
	assign fit_y = qy_s1 <= lim_y;
	assign good  = ok_s1 && fit_x && fit_y;
	assign sx    = neg_x_s1 ? -qx_s1 : qx_s1;
	assign sy    = neg_y_s1 ? -qy_s1 : qy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_vld;
			out_vld <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1    <= in_word.ok && !in_word.ovf_x && !in_word.ovf_y;
			neg_x_s1 <= in_word.neg_x;
			neg_y_s1 <= in_word.neg_y;
			qx_s1    <= {1'b0, in_word.quo_x} + (QUO_W+1)'(up_x);
			qy_s1    <= {1'b0, in_word.quo_y} + (QUO_W+1)'(up_y);

			coords_valid <= good;
			map_x        <= good ? $signed(sx[QUO_W-1:0]) : '0;
			map_y        <= good ? $signed(sy[QUO_W-1:0]) : '0;
		end
	end

endmodule

[rtl/core/homography_point_mapper_top.sv]
// ----------------------------------------------------------------------------
// homography_point_mapper_top
// Maps an image point through a 3x3 homography to Q16.16 machine coords.
//
//   channel  direction  handshake          word
//   in       sink       in_valid/in_stall  image_x, image_y
//   out      source     out_valid/out_stall map_x, map_y, coords_valid
//   cfg      sink       cfg_we             cfg_index, cfg_data
//
// One point per cycle while the output is not held; 4 front stages, 32 divider cells
// (one quotient bit each), a rounding stage and the output register.
// Reset clears all valid flags and loads the identity transform, disabled.
// A held output word stops the whole pipe; in_stall follows it.
// ----------------------------------------------------------------------------
module homography_point_mapper_top import hpm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [15:0]        image_x,
	input  logic [15:0]        image_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] map_x,
	output logic signed [31:0] map_y,
	output logic               coords_valid,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	logic        en_q;
	logic [31:0] coef_xx_q, coef_xy_q, coef_xo_q, coef_yx_q, coef_yy_q, coef_yo_q;
	logic [63:0] persp_q;
	logic        adv;

	logic      vld [QUO_W+1];
	div_word_t wrd [QUO_W+1];

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q      <= 1'b0;
			coef_xx_q <= 32'h0001_0000;
			coef_xy_q <= '0;
			coef_xo_q <= '0;
			coef_yx_q <= '0;
			coef_yy_q <= 32'h0001_0000;
			coef_yo_q <= '0;
			persp_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE:  en_q      <= cfg_data[0];
				REG_COEF_XX: coef_xx_q <= cfg_data[31:0];
				REG_COEF_XY: coef_xy_q <= cfg_data[31:0];
				REG_COEF_XO: coef_xo_q <= cfg_data[31:0];
				REG_COEF_YX: coef_yx_q <= cfg_data[31:0];
				REG_COEF_YY: coef_yy_q <= cfg_data[31:0];
				REG_COEF_YO: coef_yo_q <= cfg_data[31:0];
				REG_PERSP:   persp_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	hpm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.in_vld          (in_valid),
		.image_x         (image_x),
		.image_y         (image_y),
		.en              (en_q),
		.coef_xx         (coef_xx_q),
		.coef_xy         (coef_xy_q),
		.coef_x_offset   (coef_xo_q),
		.coef_yx         (coef_yx_q),
		.coef_yy         (coef_yy_q),
		.coef_y_offset   (coef_yo_q),
		.perspective_row (persp_q),
		.out_vld         (vld[0]),
		.out_word        (wrd[0])
	);

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		hpm_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_vld   (vld[i]),
			.in_word  (wrd[i]),
			.out_vld  (vld[i+1]),
			.out_word (wrd[i+1])
		);
	end

	hpm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_vld       (vld[QUO_W]),
		.in_word      (wrd[QUO_W]),
		.out_vld      (out_valid),
		.map_x        (map_x),
		.map_y        (map_y),
		.coords_valid (coords_valid)
	);

	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !coords_valid) |-> (map_x == '0 && map_y == '0))
		else $error("invalid word carries nonzero coordinates");

	a_held_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(map_x) && $stable(map_y) && $stable(coords_valid)))
		else $error("held output word changed");

	a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> (vld[QUO_W] == $past(vld[QUO_W])))
		else $error("divider chain moved while output held");

endmodule

[tb/tb_homography_point_mapper_top.sv]
// ----------------------------------------------------------------------------
// tb_homography_point_mapper_top
// Drives image points through the homography mapper under a series of
// register settings and checks every mapped word against a table entry or a local predictor.
// ----------------------------------------------------------------------------
module tb_homography_point_mapper_top import hpm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY  = 40;
	localparam int WATCHDOG = 3000;
	localparam int LONG_HOLD = 300;

	typedef struct {
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic               ok;
	} mapped_t;

	typedef struct {
		bit          wr;
		cfg_reg_t    idx;
		logic [63:0] val;
		logic [15:0] x;
		logic [15:0] y;
		bit          known;
		mapped_t     res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [15:0]        image_x;
	logic [15:0]        image_y;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] map_x;
	logic signed [31:0] map_y;
	logic               coords_valid;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [63:0]        cfg_data;

	// local copy of the register file
	logic               m_en;
	logic signed [31:0] m_xx, m_xy, m_xo, m_yx, m_yy, m_yo;
	logic [63:0]        m_persp;

	mapped_t pending_maps[$];
	int      errors;
	bit      quiet;
	bit      long_req;
	bit      in_acc, out_acc;

	homography_point_mapper_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// rounded |num| * 2^40 / |den|, signed Q16.16; ok low on overflow
	function automatic void ratio_q16(input longint num, input longint den,
			output logic ok, output logic signed [31:0] res);
		logic [127:0] m, d, q, r;
		bit neg;
		neg = (num < 0) != (den < 0);
		m = (num < 0) ? 128'(-num) : 128'(num);
		d = (den < 0) ? 128'(-den) : 128'(den);
		q = (m << 40) / d;
		r = (m << 40) % d;
		if (2 * r >= d)
			q = q + 1;
		ok = 1'b1;
		res = '0;
		if (neg) begin
			if (q > 128'h8000_0000)
				ok = 1'b0;
			else
				res = -q[31:0];
		end else begin
			if (q > 128'h7FFF_FFFF)
				ok = 1'b0;
			else
				res = q[31:0];
		end
	endfunction

	function automatic mapped_t map_point(input logic [15:0] x, input logic [15:0] y);
		mapped_t o;
		longint xi, yi, nx, ny, w;
		logic okx, oky;
		logic signed [31:0] rx, ry;
		xi = x;
		yi = y;
		nx = longint'(m_xx) * xi + longint'(m_xy) * yi + longint'(m_xo) * 16;
		ny = longint'(m_yx) * xi + longint'(m_yy) * yi + longint'(m_yo) * 16;
		w = longint'($signed(m_persp[31:0])) * xi + longint'($signed(m_persp[63:32])) * yi
			+ (64'sd1 <<< 44);
		o = '{mx: 0, my: 0, ok: 1'b0};
		if (m_en && w != 0) begin
			ratio_q16(nx, w, okx, rx);
			ratio_q16(ny, w, oky, ry);
			if (okx && oky)
				o = '{mx: rx, my: ry, ok: 1'b1};
		end
		return o;
	endfunction

	// cfg_we goes low again after each write, which keeps cfg_we edges apart
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ENABLE:  m_en = val[0];
			REG_COEF_XX: m_xx = val[31:0];
			REG_COEF_XY: m_xy = val[31:0];
			REG_COEF_XO: m_xo = val[31:0];
			REG_COEF_YX: m_yx = val[31:0];
			REG_COEF_YY: m_yy = val[31:0];
			REG_COEF_YO: m_yo = val[31:0];
			REG_PERSP:   m_persp = val;
		endcase
	endtask

	// sender holds off until the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_maps.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic send_point(input logic [15:0] x, input logic [15:0] y,
			input bit known, input mapped_t res);
		bit acc;
		in_valid <= 1'b1;
		image_x <= x;
		image_y <= y;
		do begin
			@(negedge clk);
			acc = !in_stall;
			@(posedge clk);
		end while (!acc);
		pending_maps.push_back(known ? res : map_point(x, y));
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 524288)) - 262144);
			3: return 32'd65536 + $urandom_range(0, 8191) - 4096;
			default: return '0;
		endcase
	endfunction

	function automatic logic [31:0] pick_persp();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2, 3: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return '0;
		endcase
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 255);
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return $urandom;
		endcase
	endfunction

	// output side: random stall bursts, one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (long_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				long_req = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// word checker, sampled mid-cycle where all signals are settled
	always @(negedge clk) begin
		mapped_t e;
		in_acc = in_valid && !in_stall && arst_n;
		out_acc = out_valid && !out_stall && arst_n;
		if (out_acc) begin
			if (pending_maps.size() == 0) begin
				$display("%0t: unexpected word x=%h y=%h v=%b", $time,
					map_x, map_y, coords_valid);
				errors++;
			end else begin
				e = pending_maps.pop_front();
				if (map_x !== e.mx) begin
					$display("%0t: map_x exp %h got %h", $time, e.mx, map_x);
					errors++;
				end
				if (map_y !== e.my) begin
					$display("%0t: map_y exp %h got %h", $time, e.my, map_y);
					errors++;
				end
				if (coords_valid !== e.ok) begin
					$display("%0t: coords_valid exp %b got %b", $time, e.ok, coords_valid);
					errors++;
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			idle = (in_acc || out_acc) ? 0 : idle + 1;
			if (idle >= WATCHDOG) begin
				$display("tb_homography_point_mapper_top: done, errors");
				$finish;
			end
		end
	end

	dir_row_t dir_rows[21] = '{
		'{0, REG_ENABLE,  64'd0,           16'd0,     16'd0,     1, '{0, 0, 0}},
		'{0, REG_ENABLE,  64'd0,           16'hFFFF,  16'hFFFF,  1, '{0, 0, 0}},
		'{1, REG_ENABLE,  64'd1,           16'd16,    16'd32,    1, '{65536, 131072, 1}},
		'{0, REG_ENABLE,  64'd0,           16'd0,     16'd0,     1, '{0, 0, 1}},
		'{0, REG_ENABLE,  64'd0,           16'hFFFF,  16'hFFFF,  1,
			'{268431360, 268431360, 1}},
		'{0, REG_ENABLE,  64'd0,           16'd1,     16'd0,     1, '{4096, 0, 1}},
		'{1, REG_COEF_XO, 64'h7FFF_FFFF,   16'd0,     16'd0,     1, '{32'h7FFF_FFFF, 0, 1}},
		'{0, REG_ENABLE,  64'd0,           16'd16,    16'd0,     1, '{0, 0, 0}},
		'{1, REG_COEF_XO, 64'd0,           16'd5,     16'd7,     0, '{0, 0, 0}},
		'{1, REG_COEF_XX, 64'h8000_0000,   16'd16,    16'd0,     1, '{32'h8000_0000, 0, 1}},
		'{0, REG_ENABLE,  64'd0,           16'd17,    16'd0,     1, '{0, 0, 0}},
		'{1, REG_COEF_XX, 64'd65536,       16'd300,   16'd40,    0, '{0, 0, 0}},
		'{1, REG_COEF_XY, 64'hFFFF_0000,   16'd300,   16'd40,    0, '{0, 0, 0}},
		'{1, REG_COEF_YX, 64'd12345,       16'd1234,  16'd99,    0, '{0, 0, 0}},
		'{1, REG_COEF_YY, 64'h8000_0000,   16'd3,     16'd2,     0, '{0, 0, 0}},
		'{1, REG_COEF_YO, 64'hFFFF_FFFF,   16'd7,     16'd1,     0, '{0, 0, 0}},
		'{1, REG_COEF_YY, 64'd65536,       16'd7,     16'd9,     0, '{0, 0, 0}},
		// g = -2^31 with x = 8192 cancels the one in w
		'{1, REG_PERSP,   64'h8000_0000,   16'd8192,  16'd0,     1, '{0, 0, 0}},
		// same g, x = 16384: w goes negative
		'{0, REG_ENABLE,  64'd0,           16'd16384, 16'd0,     0, '{0, 0, 0}},
		'{1, REG_PERSP,   64'h1234_5678_0000_1000, 16'd900, 16'd2000, 0, '{0, 0, 0}},
		'{1, REG_ENABLE,  64'd0,           16'd100,   16'd100,   1, '{0, 0, 0}}
	};

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		image_x = '0;
		image_y = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		errors = 0;
		quiet = 0;
		long_req = 0;
		m_en = 1'b0;
		m_xx = 32'd65536;
		m_xy = '0;
		m_xo = '0;
		m_yx = '0;
		m_yy = 32'd65536;
		m_yo = '0;
		m_persp = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (LATENCY) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].wr) begin
				drain();
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			end
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].known, dir_rows[i].res);
			maybe_gap();
		end

		for (int p = 0; p < 9; p++) begin
			drain();
			write_reg(REG_ENABLE, (p == 0) ? 64'd0 : 64'($urandom_range(0, 7) != 0));
			write_reg(REG_COEF_XX, 64'(pick_coef()));
			write_reg(REG_COEF_XY, 64'(pick_coef()));
			write_reg(REG_COEF_XO, 64'(pick_coef()));
			write_reg(REG_COEF_YX, 64'(pick_coef()));
			write_reg(REG_COEF_YY, 64'(pick_coef()));
			write_reg(REG_COEF_YO, 64'(pick_coef()));
			write_reg(REG_PERSP, {pick_persp(), pick_persp()});
			if (p == 3)
				long_req = 1;
			if (p == 8)
				quiet = 1;
			for (int k = 0; k < 50; k++) begin
				send_point(pick_coord(), pick_coord(), 0, '{0, 0, 0});
				maybe_gap();
			end
		end
		in_valid <= 1'b0;

		while (pending_maps.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0)
			$display("tb_homography_point_mapper_top: done, clean");
		else
			$display("tb_homography_point_mapper_top: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/core/hpm_pkg.sv
rtl/core/hpm_front.sv
rtl/core/hpm_div_cell.sv
rtl/core/hpm_back.sv
rtl/core/homography_point_mapper_top.sv
tb/tb_homography_point_mapper_top.sv
